FILE: rtl/acwa_pkg.sv
// ----------------------------------------------------------------------------
// acwa_pkg
// Shared types, constants and helpers of the ARP cache with aging.
// ----------------------------------------------------------------------------
`default_nettype none

package acwa_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IFACE_COUNT   = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    localparam int IFACE_W = 4;
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int TIME_W  = 32;
    localparam int RETRY_W = 8;
    localparam int CFG_W   = 16;
    localparam int CFGA_W  = 2;
    localparam int IN_DW   = 88;
    localparam int OUT_DW  = 88;

    localparam logic [MAC_W-1:0]   MAC_ONES  = '1;
    localparam logic [RETRY_W-1:0] RETRY_MAX = 8'hff;

    localparam logic [7:0]  MAX_TRIES_RST = 8'd5;
    localparam logic [15:0] DOWN_TIME_RST = 16'd20;
    localparam logic [15:0] KEEP_TIME_RST = 16'd1200;

    // action codes
    typedef enum logic [2:0] {
        ACT_TICK    = 3'd0,
        ACT_LEARN   = 3'd1,
        ACT_RESOLVE = 3'd2,
        ACT_DELHOST = 3'd3,
        ACT_DELALL  = 3'd4
    } t_action;

    // status codes
    typedef enum logic [2:0] {
        ST_RESOLVED = 3'd0,
        ST_PENDING  = 3'd1,
        ST_DOWN     = 3'd2,
        ST_DONE     = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    // register indexes
    typedef enum logic [CFGA_W-1:0] {
        REG_MAX_TRIES = 2'd0,
        REG_DOWN_TIME = 2'd1,
        REG_KEEP_TIME = 2'd2
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_DRAIN, S_DECIDE, S_RD1, S_WR1, S_RD2, S_WR2, S_FIN
    } t_state;

    typedef struct packed {
        logic                 valid;
        logic                 perm;
        logic                 armed;
        logic [IFACE_W-1:0]   iface;
        logic [IP_W-1:0]      ip;
        logic [MAC_W-1:0]     mac;
        logic [TIME_W-1:0]    expiry;
        logic [RETRY_W-1:0]   retries;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_rd;
        logic rd1;
        logic wr1;
        logic rd2;
        logic wr2;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic op1;
        logic op2;
        logic out_free;
    } t_sts;

    // true when time a lies strictly before time b (wrapping)
    function automatic logic before_t(input logic [TIME_W-1:0] a,
                                      input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = b - a;
        return (d != '0) && !d[TIME_W-1];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/acwa_ram.sv
// ----------------------------------------------------------------------------
// acwa_ram
// Generic one-write one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module acwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/acwa_ctrl.sv
// ----------------------------------------------------------------------------
// acwa_ctrl
// Sequencer: table scan, up to two read-modify-write passes, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module acwa_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire acwa_pkg::t_sts i_sts,
    output acwa_pkg::t_cmd     o_cmd
);
    import acwa_pkg::*;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.op1) begin
                    n_state = S_RD1;
                end else if (i_sts.op2) begin
                    n_state = S_RD2;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_RD1: begin
                o_cmd.rd1 = 1'b1;
                n_state   = S_WR1;
            end
            S_WR1: begin
                o_cmd.wr1 = 1'b1;
                n_state   = i_sts.op2 ? S_RD2 : S_FIN;
            end
            S_RD2: begin
                o_cmd.rd2 = 1'b1;
                n_state   = S_WR2;
            end
            S_WR2: begin
                o_cmd.wr2 = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/acwa_dp.sv
// ----------------------------------------------------------------------------
// acwa_dp
// Datapath: entry RAM, used bits, clock of seconds, scan match logic,
// entry update and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module acwa_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [acwa_pkg::CFGA_W-1:0]   i_cfg_addr,
    input  wire logic [acwa_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  wire logic [2:0]                    i_action,
    input  wire logic [acwa_pkg::IN_DW-1:0]    i_in_data,
    input  wire acwa_pkg::t_cmd                i_cmd,
    output acwa_pkg::t_sts                     o_sts,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [2:0]                         o_out_user,
    output logic [acwa_pkg::OUT_DW-1:0]        o_out_data
);
    import acwa_pkg::*;

    // configuration
    logic [7:0]  r_max_tries;
    logic [15:0] r_down_time;
    logic [15:0] r_keep_time;

    // captured item
    logic [2:0]         r_act;
    logic [IFACE_W-1:0] r_ifc;
    logic [IP_W-1:0]    r_ip;
    logic [MAC_W-1:0]   r_mac;
    logic               r_perm;

    logic [TIME_W-1:0]        r_now;
    logic [TABLE_ENTRIES-1:0] r_used;

    // scan state
    logic [IDX_W-1:0] r_cnt;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_hit_f, r_ipm_f, r_free_f, r_del_f;
    logic [IDX_W-1:0] r_hit_idx, r_ipm_idx, r_free_idx, r_del_idx;
    t_entry           r_hit_word;

    logic               r_out_vld;
    logic [2:0]         r_out_user;
    logic [OUT_DW-1:0]  r_out_data;

    logic [ENTRY_W-1:0] ram_rdata, ram_wdata;
    logic [IDX_W-1:0]   ram_raddr, ram_waddr;
    logic               ram_we;
    t_entry             rd_e, wr_e;

    logic             iface_ok, ip_eq, u_bit;
    logic [TIME_W-1:0] down_ext, keep_ext, max_ext;
    logic [TIME_W-1:0] age;
    logic             tgt_new;
    logic [IDX_W-1:0] tgt_idx;
    logic             stale, renew, is_down;
    logic [RETRY_W-1:0] new_ret;
    logic             op1, op2, req;
    logic [2:0]       status;
    logic [MAC_W-1:0] mac_out, l_mac;
    logic             l_perm;

    assign rd_e     = t_entry'(ram_rdata);
    assign iface_ok = int'(r_ifc) < IFACE_COUNT;
    assign down_ext = {16'b0, r_down_time};
    assign keep_ext = {16'b0, r_keep_time};
    assign max_ext  = {24'b0, r_max_tries};
    assign ip_eq    = rd_e.ip == r_ip;
    assign u_bit    = r_used[r_rd_idx];
    assign age      = r_now - rd_e.expiry;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_tries <= MAX_TRIES_RST;
            r_down_time <= DOWN_TIME_RST;
            r_keep_time <= KEEP_TIME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MAX_TRIES: r_max_tries <= i_cfg_wdata[7:0];
                REG_DOWN_TIME: r_down_time <= i_cfg_wdata;
                REG_KEEP_TIME: r_keep_time <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // capture item fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act  <= i_action;
            r_ifc  <= i_in_data[3:0];
            r_ip   <= i_in_data[35:4];
            r_mac  <= i_in_data[83:36];
            r_perm <= i_in_data[84];
        end
    end

    // decide the update passes and the result
    always_comb begin
        tgt_new = !r_ipm_f;
        tgt_idx = r_ipm_f ? r_ipm_idx : r_free_idx;
        stale   = before_t(r_hit_word.expiry - down_ext, r_now);
        renew   = before_t(r_hit_word.expiry - max_ext, r_now);
        new_ret = (r_hit_word.retries == RETRY_MAX) ? RETRY_MAX
                                                    : r_hit_word.retries + 1'b1;
        is_down = {24'b0, new_ret} >= max_ext;
        op1     = 1'b0;
        op2     = 1'b0;
        req     = 1'b0;
        status  = ST_DONE;
        mac_out = '0;
        l_mac   = MAC_ONES;
        l_perm  = 1'b0;
        if (r_act == ACT_LEARN && iface_ok) begin
            l_mac  = r_mac;
            l_perm = r_perm;
            if (r_ipm_f || r_free_f) begin
                op1 = 1'b1;
            end else begin
                status = ST_FULL;
            end
        end else if (r_act == ACT_RESOLVE && iface_ok) begin
            if (!r_hit_f) begin
                status = ST_PENDING;
                req    = 1'b1;
                op1    = r_ipm_f || r_free_f;
            end else if (!r_hit_word.valid) begin
                status = ST_PENDING;
                if (stale) begin
                    op2 = 1'b1;
                    if (is_down) begin
                        status = ST_DOWN;
                    end else begin
                        req = 1'b1;
                        op1 = 1'b1;
                    end
                end
            end else begin
                status  = ST_RESOLVED;
                mac_out = r_hit_word.mac;
                if (renew) begin
                    req = 1'b1;
                    op1 = 1'b1;
                end
            end
        end
    end

    // build the entry written back
    always_comb begin
        wr_e = rd_e;
        if (i_cmd.wr1) begin
            if (tgt_new) begin
                wr_e.valid   = 1'b0;
                wr_e.perm    = 1'b0;
                wr_e.armed   = 1'b0;
                wr_e.iface   = r_ifc;
                wr_e.ip      = r_ip;
                wr_e.mac     = l_mac;
                wr_e.expiry  = r_now;
                wr_e.retries = '0;
            end
            if (l_perm) begin
                wr_e.perm  = 1'b1;
                wr_e.armed = 1'b0;
            end
            if (l_mac != MAC_ONES) begin
                wr_e.mac    = l_mac;
                wr_e.valid  = 1'b1;
                wr_e.expiry = r_now + keep_ext;
            end else begin
                wr_e.expiry = r_now + down_ext;
            end
            if (!wr_e.perm) begin
                wr_e.armed = 1'b1;
            end
        end else begin
            wr_e.retries = new_ret;
            if (!is_down) begin
                wr_e.expiry = r_now + down_ext;
                wr_e.armed  = 1'b1;
            end
        end
    end

    // RAM port selection
    always_comb begin
        ram_raddr = r_cnt;
        if (i_cmd.rd1) begin
            ram_raddr = tgt_idx;
        end else if (i_cmd.rd2) begin
            ram_raddr = r_hit_idx;
        end
        ram_we    = i_cmd.wr1 || i_cmd.wr2;
        ram_waddr = i_cmd.wr1 ? tgt_idx : r_hit_idx;
        ram_wdata = ENTRY_W'(wr_e);
    end

    acwa_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // advance seconds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now <= '0;
        end else if (i_cmd.load && i_action == ACT_TICK) begin
            r_now <= r_now + 1'b1;
        end
    end

    // scan counter and read pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_rd;
        end
        if (i_cmd.load) begin
            r_cnt <= '0;
        end else if (i_cmd.scan_rd) begin
            r_cnt <= r_cnt + 1'b1;
        end
        r_rd_idx <= r_cnt;
    end

    // collect first matches while scanning
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hit_f  <= 1'b0;
            r_ipm_f  <= 1'b0;
            r_free_f <= 1'b0;
            r_del_f  <= 1'b0;
        end else if (r_rd_vld) begin
            if (u_bit && ip_eq && !r_ipm_f) begin
                r_ipm_f   <= 1'b1;
                r_ipm_idx <= r_rd_idx;
            end
            if (u_bit && ip_eq && rd_e.iface == r_ifc && !r_hit_f) begin
                r_hit_f    <= 1'b1;
                r_hit_idx  <= r_rd_idx;
                r_hit_word <= rd_e;
            end
            if (!u_bit && !r_free_f) begin
                r_free_f   <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
            if (u_bit && !rd_e.perm && ip_eq && !r_del_f) begin
                r_del_f   <= 1'b1;
                r_del_idx <= r_rd_idx;
            end
        end
    end

    // used bits: age out, bulk delete, allocate, host delete
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (r_rd_vld) begin
            if (r_act == ACT_TICK && u_bit && rd_e.armed && !age[TIME_W-1]) begin
                r_used[r_rd_idx] <= 1'b0;
            end
            if (r_act == ACT_DELALL && u_bit && !rd_e.perm) begin
                r_used[r_rd_idx] <= 1'b0;
            end
        end else if (i_cmd.wr1 && tgt_new) begin
            r_used[tgt_idx] <= 1'b1;
        end else if (i_cmd.finish && r_act == ACT_DELHOST && r_del_f) begin
            r_used[r_del_idx] <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (i_cmd.finish) begin
            r_out_user <= status;
            r_out_data <= {3'b0,
                           req ? r_ifc : {IFACE_W{1'b0}},
                           req ? r_ip : {IP_W{1'b0}},
                           req,
                           mac_out};
        end
    end

    assign o_sts.scan_last = r_cnt == IDX_W'(TABLE_ENTRIES - 1);
    assign o_sts.op1       = op1;
    assign o_sts.op2       = op2;
    assign o_sts.out_free  = !r_out_vld || i_out_ready;
    assign o_out_valid     = r_out_vld;
    assign o_out_user      = r_out_user;
    assign o_out_data      = r_out_data;

endmodule

`default_nettype wire

FILE: rtl/arp_cache_with_aging.sv
// ----------------------------------------------------------------------------
// arp_cache_with_aging
// ARP neighbor cache with per-entry aging, learn, resolve and delete.
// ----------------------------------------------------------------------------
// One item at a time. Each item walks the whole table through the single
// read port of the entry RAM, one entry per cycle, then applies up to two
// read-modify-write passes, each a read state and a write state. The result
// sits in an output register, so a new item is taken while the previous
// result waits. There is no clearing pass: used bits are flops cleared at
// reset. The user must write configuration only while the block is idle;
// the block itself does not enforce this.
`default_nettype none

module arp_cache_with_aging (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration
    input  wire logic                        i_cfg_we,
    input  wire logic [acwa_pkg::CFGA_W-1:0] i_cfg_addr,
    input  wire logic [acwa_pkg::CFG_W-1:0]  i_cfg_wdata,
    // item input
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    // iface[3:0], ip_addr[35:4], mac_addr[83:36], make_permanent[84], pad
    input  wire logic [acwa_pkg::IN_DW-1:0]  s_axis_tdata,
    // action[2:0]
    input  wire logic [2:0]                  s_axis_tuser,
    // result output
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // mac_out[47:0], send_request[48], request_ip[80:49],
    // request_iface[84:81], pad
    output logic [acwa_pkg::OUT_DW-1:0]      m_axis_tdata,
    // status[2:0]
    output logic [2:0]                       m_axis_tuser
);
    import acwa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    acwa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    acwa_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata),
        .i_action   (s_axis_tuser),
        .i_in_data  (s_axis_tdata),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_out_user (m_axis_tuser),
        .o_out_data (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: sim/arp_cache_with_aging_test.sv
// ----------------------------------------------------------------------------
// arp_cache_with_aging_test
// Self-checking bench for the ARP cache: a behavioral copy of the table
// predicts every result, stimulus mixes directed cases, retry saturation,
// table fill, aging under several register settings and random stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arp_cache_with_aging_test;
    import acwa_pkg::*;

    localparam int  LIMIT_CYCLES  = 3_000_000;
    localparam int  SETTLE_CYCLES = 100;
    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

    typedef struct {
        t_status            st;
        logic [MAC_W-1:0]   mac;
        logic               req;
        logic [IP_W-1:0]    rip;
        logic [IFACE_W-1:0] rif;
    } t_answer;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFGA_W-1:0]   i_cfg_addr;
    logic [CFG_W-1:0]    i_cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_DW-1:0]    s_axis_tdata;
    logic [2:0]          s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_DW-1:0]   m_axis_tdata;
    logic [2:0]          m_axis_tuser;

    // behavioral copy of the table
    bit                  bind_used [TABLE_ENTRIES];
    bit                  bind_valid[TABLE_ENTRIES];
    bit                  bind_perm [TABLE_ENTRIES];
    bit                  bind_armed[TABLE_ENTRIES];
    logic [IFACE_W-1:0]  bind_ifc  [TABLE_ENTRIES];
    logic [IP_W-1:0]     bind_ip   [TABLE_ENTRIES];
    logic [MAC_W-1:0]    bind_mac  [TABLE_ENTRIES];
    logic [TIME_W-1:0]   bind_exp  [TABLE_ENTRIES];
    logic [RETRY_W-1:0]  bind_tries[TABLE_ENTRIES];
    logic [TIME_W-1:0]   clock_secs;
    logic [7:0]          tries_limit;
    logic [15:0]         down_secs;
    logic [15:0]         keep_secs;

    t_answer             answers_due[$];
    logic [IP_W-1:0]     host_pool[96];
    int                  cycles;
    int                  errors;
    int                  sent;
    int                  checked;
    int                  full_seen;
    int                  down_seen;
    int                  rx_hold;
    bit                  calm;

    arp_cache_with_aging DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // 8 ns clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results outstanding", $time, answers_due.size());
            $display("arp_cache_with_aging_test failed");
            $finish;
        end
    end

    // wrapping time order: a strictly earlier than b
    function automatic bit earlier(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = b - a;
        return (d != '0) && !d[TIME_W-1];
    endfunction

    function automatic int slot_of_ip(logic [IP_W-1:0] ip);
        for (int k = 0; k < TABLE_ENTRIES; k++)
            if (bind_used[k] && bind_ip[k] == ip) return k;
        return -1;
    endfunction

    // insert or refresh a binding matched on IP only; -1 when table full
    function automatic int learn_binding(logic [IFACE_W-1:0] ifc, logic [IP_W-1:0] ip,
                                         logic [MAC_W-1:0] mac, bit perm);
        int k;
        k = slot_of_ip(ip);
        if (k < 0) begin
            for (int j = 0; j < TABLE_ENTRIES; j++)
                if (!bind_used[j]) begin
                    k = j;
                    break;
                end
            if (k < 0) return -1;
            bind_used[k]  = 1'b1;
            bind_valid[k] = 1'b0;
            bind_perm[k]  = 1'b0;
            bind_armed[k] = 1'b0;
            bind_ifc[k]   = ifc;
            bind_ip[k]    = ip;
            bind_mac[k]   = mac;
            bind_exp[k]   = clock_secs;
            bind_tries[k] = '0;
        end
        if (perm) begin
            bind_perm[k]  = 1'b1;
            bind_armed[k] = 1'b0;
        end
        if (mac != MAC_ONES) begin
            bind_mac[k]   = mac;
            bind_valid[k] = 1'b1;
            bind_exp[k]   = clock_secs + TIME_W'(keep_secs);
        end else begin
            bind_exp[k] = clock_secs + TIME_W'(down_secs);
        end
        if (!bind_perm[k]) bind_armed[k] = 1'b1;
        return k;
    endfunction

    function automatic t_answer predict_answer(logic [2:0] act, logic [IFACE_W-1:0] ifc,
                                               logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac,
                                               bit perm);
        t_answer a;
        int      hit;
        a = '{ST_DONE, '0, 1'b0, '0, '0};
        hit = -1;
        case (act)
            ACT_TICK: begin
                clock_secs = clock_secs + 1;
                for (int k = 0; k < TABLE_ENTRIES; k++) begin
                    logic [TIME_W-1:0] age;
                    age = clock_secs - bind_exp[k];
                    if (bind_used[k] && bind_armed[k] && !age[TIME_W-1]) bind_used[k] = 1'b0;
                end
            end
            ACT_LEARN: begin
                if (int'(ifc) < IFACE_COUNT && learn_binding(ifc, ip, mac, perm) < 0)
                    a.st = ST_FULL;
            end
            ACT_RESOLVE: begin
                if (int'(ifc) < IFACE_COUNT) begin
                    for (int k = 0; k < TABLE_ENTRIES; k++)
                        if (bind_used[k] && bind_ifc[k] == ifc && bind_ip[k] == ip) begin
                            hit = k;
                            break;
                        end
                    if (hit < 0) begin
                        void'(learn_binding(ifc, ip, MAC_ONES, 1'b0));
                        a.req = 1'b1;
                        a.st  = ST_PENDING;
                    end else if (!bind_valid[hit]) begin
                        a.st = ST_PENDING;
                        if (earlier(bind_exp[hit] - TIME_W'(down_secs), clock_secs)) begin
                            if (bind_tries[hit] < RETRY_MAX) bind_tries[hit]++;
                            if (bind_tries[hit] >= tries_limit) begin
                                a.st = ST_DOWN;
                            end else begin
                                void'(learn_binding(ifc, ip, MAC_ONES, 1'b0));
                                a.req = 1'b1;
                                bind_exp[hit]   = clock_secs + TIME_W'(down_secs);
                                bind_armed[hit] = 1'b1;
                            end
                        end
                    end else begin
                        a.st  = ST_RESOLVED;
                        a.mac = bind_mac[hit];
                        if (earlier(bind_exp[hit] - TIME_W'(tries_limit), clock_secs)) begin
                            void'(learn_binding(ifc, ip, MAC_ONES, 1'b0));
                            a.req = 1'b1;
                        end
                    end
                end
            end
            ACT_DELHOST: begin
                for (int k = 0; k < TABLE_ENTRIES; k++)
                    if (bind_used[k] && !bind_perm[k] && bind_ip[k] == ip) begin
                        bind_used[k] = 1'b0;
                        break;
                    end
            end
            ACT_DELALL: begin
                for (int k = 0; k < TABLE_ENTRIES; k++)
                    if (bind_used[k] && !bind_perm[k]) bind_used[k] = 1'b0;
            end
            default: ;
        endcase
        if (a.req) begin
            a.rip = ip;
            a.rif = ifc;
        end
        return a;
    endfunction

    // offer one item and wait for its transfer; tvalid stays high on return
    task automatic send_item(logic [2:0] act, logic [IFACE_W-1:0] ifc, logic [IP_W-1:0] ip,
                             logic [MAC_W-1:0] mac, bit perm);
        if (!calm && $urandom_range(99) < 13) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {3'b000, perm, mac, ip, ifc};
        do @(negedge i_clk); while (!s_axis_tready);
        @(posedge i_clk);
        answers_due.push_back(predict_answer(act, ifc, ip, mac, perm));
        sent++;
    endtask

    // stop offering and wait until every result has arrived
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg idx, logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_MAX_TRIES: tries_limit = val[7:0];
            REG_DOWN_TIME: down_secs   = val;
            REG_KEEP_TIME: keep_secs   = val;
            default: ;
        endcase
    endtask

    task automatic set_timers(logic [7:0] mt, logic [15:0] dt, logic [15:0] kt);
        drain();
        write_reg(REG_MAX_TRIES, CFG_W'(mt));
        write_reg(REG_DOWN_TIME, dt);
        write_reg(REG_KEEP_TIME, kt);
    endtask

    // random traffic over the first span hosts of the pool
    task automatic run_random(int count, int span, int tick_pct);
        logic [2:0]         act;
        logic [IFACE_W-1:0] ifc;
        logic [MAC_W-1:0]   mac;
        int                 roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < tick_pct)            act = ACT_TICK;
            else if (roll < tick_pct + 30)  act = ACT_LEARN;
            else if (roll < 92)             act = ACT_RESOLVE;
            else if (roll < 97)             act = ACT_DELHOST;
            else if (roll < 98)             act = ACT_DELALL;
            else act = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
            ifc = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(2));
            case ($urandom_range(5))
                0:       mac = MAC_ONES;
                1:       mac = '0;
                default: mac = {16'($urandom), 32'($urandom)};
            endcase
            send_item(act, ifc, host_pool[$urandom_range(span - 1)], mac,
                      $urandom_range(15) == 0);
        end
    endtask

    task automatic test_directed();
        send_item(ACT_LEARN, 4'd0, 32'h0000_0000, 48'h0, 1'b0);
        send_item(ACT_LEARN, 4'd15, 32'hffff_ffff, 48'hffff_ffff_fffe, 1'b1);
        send_item(ACT_RESOLVE, 4'd0, 32'h0000_0000, 48'h0, 1'b0);
        send_item(ACT_RESOLVE, 4'd15, 32'hffff_ffff, 48'h0, 1'b0);
        // miss, then another interface holding the same address
        send_item(ACT_RESOLVE, 4'd3, 32'h0a00_0001, 48'h0, 1'b0);
        send_item(ACT_RESOLVE, 4'd5, 32'h0000_0000, 48'h0, 1'b0);
        send_item(ACT_RESOLVE, 4'd3, 32'h0a00_0001, 48'h0, 1'b0);
        send_item(ACT_LEARN, 4'd7, 32'h0a00_0001, MAC_ONES, 1'b0);
        send_item(ACT_LEARN, 4'd8, 32'h0a00_0002, MAC_ONES, 1'b1);
        send_item(ACT_RESOLVE, 4'd8, 32'h0a00_0002, 48'h0, 1'b0);
        send_item(ACT_TICK, 4'd0, 32'h0, 48'h0, 1'b0);
        send_item(ACT_LEARN, 4'd0, 32'h0000_0000, 48'h8000_0000_0001, 1'b1);
        send_item(ACT_DELHOST, 4'd0, 32'hffff_ffff, 48'h0, 1'b0);
        send_item(ACT_DELHOST, 4'd0, 32'h0a00_0001, 48'h0, 1'b0);
        send_item(ACT_RESOLVE, 4'd3, 32'h0a00_0001, 48'h0, 1'b0);
        for (logic [3:0] a = 4'(ACT_SPARE_FIRST); a <= 4'(ACT_SPARE_LAST); a++)
            send_item(a[2:0], 4'd1, 32'h0a00_0001, 48'h0, 1'b0);
        send_item(ACT_DELALL, 4'd0, 32'h0, 48'h0, 1'b0);
        send_item(ACT_RESOLVE, 4'd15, 32'hffff_ffff, 48'h0, 1'b0);
        send_item(ACT_RESOLVE, 4'd0, 32'h0a00_0001, 48'h0, 1'b0);
        drain();
    endtask

    // resolve and tick in turn until the retry count pins at its ceiling
    task automatic test_retry_saturation();
        set_timers(8'd255, 16'd2, 16'd3);
        for (int n = 0; n < 262; n++) begin
            send_item(ACT_RESOLVE, 4'd9, 32'hc0a8_0101, 48'h0, 1'b0);
            send_item(ACT_TICK, 4'd0, 32'h0, 48'h0, 1'b0);
        end
    endtask

    // hold the result side off while items keep coming
    task automatic test_backpressure();
        @(negedge i_clk);
        rx_hold = 400;
        run_random(30, 8, 10);
        drain();
    endtask

    initial begin
        cycles = 0;
        errors = 0;
        sent = 0;
        checked = 0;
        full_seen = 0;
        down_seen = 0;
        rx_hold = 0;
        calm = 1'b0;
        for (int k = 0; k < TABLE_ENTRIES; k++) bind_used[k] = 1'b0;
        clock_secs  = '0;
        tries_limit = MAX_TRIES_RST;
        down_secs   = DOWN_TIME_RST;
        keep_secs   = KEEP_TIME_RST;
        for (int k = 0; k < 96; k++) host_pool[k] = 32'($urandom);
        host_pool[0] = 32'h0;
        host_pool[1] = 32'hffff_ffff;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        run_random(350, 12, 20);
        test_backpressure();
        test_retry_saturation();
        // shortest timers: everything ages fast
        set_timers(8'd1, 16'd1, 16'd1);
        run_random(200, 10, 30);
        // longest timers over a wide host pool fill the table
        set_timers(8'd255, 16'hffff, 16'hffff);
        run_random(250, 96, 5);
        set_timers(8'd3, 16'd2, 16'd6);
        calm = 1'b1;
        run_random(150, 10, 30);
        calm = 1'b0;
        run_random(250, 10, 30);
        set_timers(8'd2, 16'd4, 16'd9);
        run_random(200, 16, 25);
        drain();

        $display("%0d items sent, %0d results checked; %0d full-table and %0d host-down answers",
                 sent, checked, full_seen, down_seen);
        $display("directed cases, retry ceiling, aging at extreme timers, fill and stalls");
        if (errors == 0) begin
            $display("arp_cache_with_aging_test passed");
        end else begin
            $display("arp_cache_with_aging_test failed");
        end
        $finish;
    end

    // result side ready: long hold-off on request, else random stalls unless calm
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= 13);
        end
    end

    // compare each result transfer with the oldest prediction
    always @(negedge i_clk) begin
        t_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            checked++;
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result status %0d", $time, m_axis_tuser);
                errors++;
            end else begin
                want = answers_due.pop_front();
                if (want.st == ST_FULL) full_seen++;
                if (want.st == ST_DOWN) down_seen++;
                if (m_axis_tuser != want.st) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.st, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[47:0] != want.mac) begin
                    $display("%0t: mac_out expected %h actual %h", $time, want.mac,
                             m_axis_tdata[47:0]);
                    errors++;
                end
                if (m_axis_tdata[48] != want.req) begin
                    $display("%0t: send_request expected %b actual %b", $time, want.req,
                             m_axis_tdata[48]);
                    errors++;
                end
                if (m_axis_tdata[80:49] != want.rip) begin
                    $display("%0t: request_ip expected %h actual %h", $time, want.rip,
                             m_axis_tdata[80:49]);
                    errors++;
                end
                if (m_axis_tdata[84:81] != want.rif) begin
                    $display("%0t: request_iface expected %0d actual %0d", $time, want.rif,
                             m_axis_tdata[84:81]);
                    errors++;
                end
            end
        end
    end

endmodule
